>>> hw/rtl/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types, geometry constants and codes for the text console writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

	// Screen geometry
	localparam int COLS      = 80;
	localparam int ROWS      = 25;
	localparam int TAB_WIDTH = 5;
	localparam int NCELLS    = COLS * ROWS;

	localparam int COL_W   = $clog2(COLS);
	localparam int ROW_W   = $clog2(ROWS + 1);
	localparam int CELL_AW = $clog2(NCELLS);
	localparam int CUR_W   = 12;

	localparam logic [15:0] BLANK_CELL = 16'h1F00;
	localparam logic [7:0]  DFLT_COLOR_RST = 8'h1F;

	// Transaction modes
	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_READ  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	// Control bytes
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_READ,
		ST_SCROLL,
		ST_FILL,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [7:0]  char_code;
		logic [7:0]  attr_color;
		logic [10:0] cell_index;
	} req_item_t;

	typedef struct packed {
		logic [CUR_W-1:0] cursor_index;
		logic [7:0]       read_char;
		logic [7:0]       read_attr;
	} rsp_item_t;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} cursor_t;

	typedef struct packed {
		logic               we;
		logic [CELL_AW-1:0] addr;
		logic [15:0]        data;
	} cell_wr_t;

	// Linear cursor position sent to the display
	function automatic logic [CUR_W-1:0] cursor_index(input cursor_t c);
		return CUR_W'(c.row) * CUR_W'(COLS) + CUR_W'(c.col);
	endfunction

endpackage

>>> hw/rtl/tccw_if.sv
// ----------------------------------------------------------------------------
// tccw_if
// Valid/ready channels for request and response transactions.
// ----------------------------------------------------------------------------
interface tccw_req_if;
	logic                  valid;
	logic                  ready;
	tccw_pkg::req_item_t   data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tccw_rsp_if;
	logic                  valid;
	logic                  ready;
	tccw_pkg::rsp_item_t   data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/tccw_engine.sv
// ----------------------------------------------------------------------------
// tccw_engine
// Byte interpreter: next cursor and the single cell write for one byte.
// Expects the cursor row to be below ROWS (scroll already done).
// ----------------------------------------------------------------------------
module tccw_engine (
	input  tccw_pkg::cursor_t  cur,
	input  logic [7:0]         char_code,
	input  logic [7:0]         attr_color,
	input  logic [7:0]         dflt_color,
	output tccw_pkg::cursor_t  nxt,
	output tccw_pkg::cell_wr_t wr
);

	logic [tccw_pkg::CELL_AW-1:0] base;
	logic                         last_col;
	logic                         tab_wraps;

	// Linear address of the cursor cell
	assign base = tccw_pkg::CELL_AW'(cur.row) * tccw_pkg::CELL_AW'(tccw_pkg::COLS)
		+ tccw_pkg::CELL_AW'(cur.col);
	assign last_col  = (int'(cur.col) == tccw_pkg::COLS - 1);
	assign tab_wraps = (int'(cur.col) + tccw_pkg::TAB_WIDTH + 1 > tccw_pkg::COLS);

	always_comb begin
		nxt     = cur;
		wr.we   = 1'b0;
		wr.addr = base;
		wr.data = {dflt_color, tccw_pkg::CH_SPACE};
		case (char_code)
			tccw_pkg::CH_NL: begin
				nxt.row = cur.row + 1'b1;
				nxt.col = '0;
			end
			tccw_pkg::CH_CR: begin
				nxt.col = '0;
			end
			tccw_pkg::CH_TAB: begin
				if (tab_wraps) begin
					nxt.row = cur.row + 1'b1;
					nxt.col = '0;
				end else begin
					nxt.col = cur.col + tccw_pkg::COL_W'(tccw_pkg::TAB_WIDTH);
				end
			end
			tccw_pkg::CH_BS: begin
				// blank the cell left of the cursor, across the line start
				wr.addr = base - 1'b1;
				if (cur.col == '0) begin
					if (cur.row != '0) begin
						nxt.row = cur.row - 1'b1;
						nxt.col = tccw_pkg::COL_W'(tccw_pkg::COLS - 1);
						wr.we   = 1'b1;
					end
				end else begin
					nxt.col = cur.col - 1'b1;
					wr.we   = 1'b1;
				end
			end
			default: begin
				// printable 0x20..0x7F, everything else ignored
				if (!char_code[7] && (char_code[6:5] != 2'b00)) begin
					wr.we   = 1'b1;
					wr.data = {attr_color, char_code};
					if (last_col) begin
						nxt.col = '0;
						nxt.row = cur.row + 1'b1;
					end else begin
						nxt.col = cur.col + 1'b1;
					end
				end
			end
		endcase
	end

endmodule

>>> hw/rtl/text_console_char_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_char_writer_top
// Text-mode console: screen cell store, cursor and byte interpreter.
// ----------------------------------------------------------------------------
// Each request transaction yields one response carrying the cursor index.
// A printable or control byte is handled in the cycle it is accepted unless
// a scroll is pending, so plain text streams at one byte per clock while the
// response channel is ready. A read is answered from the registered store
// read in the READ state. Clear sweeps the cell store one cell per cycle; a
// write while the cursor sits below the last row first scrolls by copying
// NCELLS-COLS cells and blanking one row, one cell per cycle through the
// single store write port. After reset the same sweep blanks the store before
// the first request is taken; configuration writes are taken at any time.
// ----------------------------------------------------------------------------
module text_console_char_writer_top (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [7:0]       cfg_data,
	tccw_req_if.sink         req,
	tccw_rsp_if.source       rsp
);

	localparam int AW = tccw_pkg::CELL_AW;

	tccw_pkg::state_t    state_q, state_d;
	logic [AW-1:0]       cnt_q, cnt_d;
	tccw_pkg::cursor_t   cur_q, cur_d;
	logic [7:0]          dflt_q;
	logic [7:0]          ch_q, attr_q;
	logic                latch_byte;
	logic                cp_v_s1, cp_v_d;
	logic [AW-1:0]       cp_addr_s1;
	logic [15:0]         rd_data_q;
	logic                out_valid_q;
	tccw_pkg::rsp_item_t out_data_q, out_d;
	logic                out_load;
	logic                accept;

	// Cell store ports
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [15:0]   mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [15:0]   mem [tccw_pkg::NCELLS];

	// Byte interpreter
	tccw_pkg::cursor_t  eng_nxt;
	tccw_pkg::cell_wr_t eng_wr;
	logic [7:0]         eng_ch, eng_attr;

	assign eng_ch   = (state_q == tccw_pkg::ST_EXEC) ? ch_q : req.data.char_code;
	assign eng_attr = (state_q == tccw_pkg::ST_EXEC) ? attr_q : req.data.attr_color;

	tccw_engine u_engine (
		.cur        (cur_q),
		.char_code  (eng_ch),
		.attr_color (eng_attr),
		.dflt_color (dflt_q),
		.nxt        (eng_nxt),
		.wr         (eng_wr)
	);

	// Handshakes
	assign req.ready = (state_q == tccw_pkg::ST_IDLE) && (!out_valid_q || rsp.ready);
	assign accept    = req.valid && req.ready;
	assign rsp.valid = out_valid_q;
	assign rsp.data  = out_data_q;

	// Next state, store access and response
	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		cur_d      = cur_q;
		latch_byte = 1'b0;
		cp_v_d     = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = cnt_q;
		mem_wdata  = tccw_pkg::BLANK_CELL;
		mem_re     = 1'b0;
		mem_raddr  = cnt_q;
		out_load   = 1'b0;
		out_d      = '{cursor_index: tccw_pkg::cursor_index(cur_q),
			read_char: 8'h00, read_attr: 8'h00};
		case (state_q)
			tccw_pkg::ST_CLR: begin
				mem_we = 1'b1;
				if (cnt_q == AW'(tccw_pkg::NCELLS - 1)) begin
					cnt_d   = '0;
					state_d = tccw_pkg::ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			tccw_pkg::ST_IDLE: begin
				if (accept) begin
					case (req.data.mode)
						tccw_pkg::MODE_WRITE: begin
							if (int'(cur_q.row) >= tccw_pkg::ROWS) begin
								latch_byte = 1'b1;
								cnt_d      = '0;
								state_d    = tccw_pkg::ST_SCROLL;
							end else begin
								mem_we             = eng_wr.we;
								mem_waddr          = eng_wr.addr;
								mem_wdata          = eng_wr.data;
								cur_d              = eng_nxt;
								out_load           = 1'b1;
								out_d.cursor_index = tccw_pkg::cursor_index(eng_nxt);
							end
						end
						tccw_pkg::MODE_READ: begin
							if (int'(req.data.cell_index) < tccw_pkg::NCELLS) begin
								mem_re    = 1'b1;
								mem_raddr = AW'(req.data.cell_index);
								state_d   = tccw_pkg::ST_READ;
							end else begin
								out_load = 1'b1;
							end
						end
						tccw_pkg::MODE_CLEAR: begin
							cur_d              = '0;
							cnt_d              = '0;
							out_load           = 1'b1;
							out_d.cursor_index = '0;
							state_d            = tccw_pkg::ST_CLR;
						end
						default: begin
							out_load = 1'b1;
						end
					endcase
				end
			end
			tccw_pkg::ST_READ: begin
				out_load        = 1'b1;
				out_d.read_char = rd_data_q[7:0];
				out_d.read_attr = rd_data_q[15:8];
				state_d         = tccw_pkg::ST_IDLE;
			end
			tccw_pkg::ST_SCROLL: begin
				// read cell i+COLS now, write it to cell i next cycle
				mem_we    = cp_v_s1;
				mem_waddr = cp_addr_s1;
				mem_wdata = rd_data_q;
				mem_re    = 1'b1;
				mem_raddr = AW'(cnt_q + AW'(tccw_pkg::COLS));
				cp_v_d    = 1'b1;
				if (cnt_q == AW'(tccw_pkg::NCELLS - tccw_pkg::COLS - 1)) begin
					cnt_d   = AW'(tccw_pkg::NCELLS - tccw_pkg::COLS);
					state_d = tccw_pkg::ST_FILL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			tccw_pkg::ST_FILL: begin
				mem_we = 1'b1;
				if (cp_v_s1) begin
					// last copy still in flight
					mem_waddr = cp_addr_s1;
					mem_wdata = rd_data_q;
				end else if (cnt_q == AW'(tccw_pkg::NCELLS - 1)) begin
					cnt_d     = '0;
					cur_d.row = tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1);
					state_d   = tccw_pkg::ST_EXEC;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			tccw_pkg::ST_EXEC: begin
				mem_we             = eng_wr.we;
				mem_waddr          = eng_wr.addr;
				mem_wdata          = eng_wr.data;
				cur_d              = eng_nxt;
				out_load           = 1'b1;
				out_d.cursor_index = tccw_pkg::cursor_index(eng_nxt);
				state_d            = tccw_pkg::ST_IDLE;
			end
			default: begin
				state_d = tccw_pkg::ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tccw_pkg::ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			cur_q       <= '0;
			dflt_q      <= tccw_pkg::DFLT_COLOR_RST;
			cp_v_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			cnt_q   <= cnt_d;
			cur_q   <= cur_d;
			cp_v_s1 <= cp_v_d;
			if (cfg_we) begin
				dflt_q <= cfg_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		cp_addr_s1 <= cnt_q;
		if (latch_byte) begin
			ch_q   <= req.data.char_code;
			attr_q <= req.data.attr_color;
		end
		if (out_load) begin
			out_data_q <= out_d;
		end
	end

	// Cell store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem[mem_raddr];
		end
	end

endmodule

>>> tb/sv/tccw_char_writer_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tccw_char_writer_checker
// Watches the request, response and color write ports of the console writer.
// Keeps its own screen image, cursor and backspace color, works out the
// response of every accepted request and compares each accepted response,
// field by field, with the oldest one still owed. Failures are counted.
// ----------------------------------------------------------------------------
module tccw_char_writer_checker
	import tccw_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_we,
	input  logic  [7:0] cfg_data,
	tccw_req_if   req,
	tccw_rsp_if   rsp,
	output int    fail_count,
	output int    outstanding
);

	// Shadow of the console state
	logic [15:0]      screen [NCELLS];
	logic [ROW_W-1:0] cur_row;
	logic [COL_W-1:0] cur_col;
	logic [7:0]       bs_color;

	// Responses owed, oldest first
	rsp_item_t pending_rsp [$];

	function automatic void blank_screen();
		for (int i = 0; i < NCELLS; i++)
			screen[i] = BLANK_CELL;
	endfunction

	// Apply one request to the shadow state and return its response
	function automatic rsp_item_t console_step(input req_item_t it);
		int        r;
		int        c;
		rsp_item_t res;
		r   = cur_row;
		c   = cur_col;
		res = '0;
		case (it.mode)
			MODE_WRITE: begin
				// pending scroll: shift up one line, blank the bottom line
				if (r >= ROWS) begin
					for (int i = 0; i < NCELLS - COLS; i++)
						screen[i] = screen[i + COLS];
					for (int i = NCELLS - COLS; i < NCELLS; i++)
						screen[i] = BLANK_CELL;
					r = ROWS - 1;
				end
				case (it.char_code)
					CH_NL: begin
						r++;
						c = 0;
					end
					CH_TAB: begin
						if (COLS - c < TAB_WIDTH + 1) begin
							r++;
							c = 0;
						end else begin
							c += TAB_WIDTH;
						end
					end
					CH_BS: begin
						// at home nothing happens; at line start go up a row
						if (c == 0) begin
							if (r != 0) begin
								r--;
								c = COLS - 1;
								screen[r * COLS + c] = {bs_color, CH_SPACE};
							end
						end else begin
							c--;
							screen[r * COLS + c] = {bs_color, CH_SPACE};
						end
					end
					CH_CR: c = 0;
					default: begin
						// printable bytes only; the rest is ignored
						if (it.char_code >= CH_SPACE && !it.char_code[7]) begin
							screen[r * COLS + c] = {it.attr_color, it.char_code};
							c++;
						end
					end
				endcase
				if (c >= COLS) begin
					c = 0;
					r++;
				end
			end
			MODE_READ: begin
				if (it.cell_index < NCELLS) begin
					res.read_char = screen[it.cell_index][7:0];
					res.read_attr = screen[it.cell_index][15:8];
				end
			end
			MODE_CLEAR: begin
				blank_screen();
				r = 0;
				c = 0;
			end
			default: ;
		endcase
		cur_row          = ROW_W'(r);
		cur_col          = COL_W'(c);
		res.cursor_index = CUR_W'(r * COLS + c);
		return res;
	endfunction

	task automatic check_field(input string field, input logic [CUR_W-1:0] want,
			input logic [CUR_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_count++;
		end
	endtask

	// Predict on request, compare on response
	always @(posedge clk or negedge arst_n) begin
		rsp_item_t want;
		if (!arst_n) begin
			blank_screen();
			cur_row    = '0;
			cur_col    = '0;
			bs_color   = DFLT_COLOR_RST;
			fail_count = 0;
			pending_rsp.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				bs_color = cfg_data;
			if (req.valid && req.ready)
				pending_rsp.push_back(console_step(req.data));
			if (rsp.valid && rsp.ready) begin
				if (pending_rsp.size() == 0) begin
					$error("response transaction with none owed, cursor_index %0d",
						rsp.data.cursor_index);
					fail_count++;
				end else begin
					want = pending_rsp.pop_front();
					check_field("cursor_index", want.cursor_index, rsp.data.cursor_index);
					check_field("read_char", CUR_W'(want.read_char), CUR_W'(rsp.data.read_char));
					check_field("read_attr", CUR_W'(want.read_attr), CUR_W'(rsp.data.read_attr));
				end
			end
			outstanding <= pending_rsp.size();
		end
	end

endmodule

>>> tb/sv/tb_text_console_char_writer_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_text_console_char_writer_top
// Drives the text console writer with a directed opening and random traffic
// in several color settings, with random idling on both channels, a long
// response hold-off and drain pauses between phases. The checker does the
// prediction and comparison; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_text_console_char_writer_top;
	import tccw_pkg::*;

	localparam logic [1:0] MODE_UNUSED = 2'd3;

	localparam int IDX_LAST        = 2047;
	localparam int IDLE_PCT        = 37;
	localparam int NUM_PHASES      = 4;
	localparam int ITEMS_PER_PHASE = 170;
	localparam int SND_STEADY_FROM = 400;
	localparam int SND_STEADY_TO   = 520;
	localparam int RCV_STEADY_FROM = 100;
	localparam int RCV_STEADY_TO   = 220;
	localparam int HOLD_AT_RSP     = 300;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_CYCLES    = 2100;

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_data;
	int         fail_count;
	int         outstanding;
	bit         sender_steady;

	tccw_req_if req_ch ();
	tccw_rsp_if rsp_ch ();

	text_console_char_writer_top uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	tccw_char_writer_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_data    (cfg_data),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Offer one request transaction; returns at the edge that accepts it
	task automatic send_txn(input req_item_t it);
		while (!sender_steady && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= it;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
	endtask

	task automatic send_op(input logic [1:0] mode, input logic [7:0] ch,
			input logic [7:0] attr, input logic [10:0] idx);
		req_item_t it;
		it.mode       = mode;
		it.char_code  = ch;
		it.attr_color = attr;
		it.cell_index = idx;
		send_txn(it);
	endtask

	// Stop offering and wait until every response has come back
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	task automatic write_color(input logic [7:0] value);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// Mostly text with line feeds and editing bytes, plus reads, unused modes and rare clears
	function automatic req_item_t random_item();
		req_item_t it;
		int        k;
		it.mode       = MODE_WRITE;
		it.char_code  = 8'($urandom_range(255));
		it.attr_color = 8'($urandom_range(255));
		it.cell_index = 11'($urandom_range(IDX_LAST));
		k = $urandom_range(999);
		if (k < 5) begin
			it.mode = MODE_CLEAR;
		end else if (k < 25) begin
			it.mode = MODE_UNUSED;
		end else if (k < 165) begin
			it.mode = MODE_READ;
			case ($urandom_range(3))
				0: it.cell_index = 11'($urandom_range(IDX_LAST));
				1: it.cell_index = 11'($urandom_range(3 * COLS - 1));
				2: it.cell_index = 11'($urandom_range(NCELLS - 1, NCELLS - 2 * COLS));
				default: it.cell_index = 11'($urandom_range(IDX_LAST, NCELLS));
			endcase
		end else begin
			k = $urandom_range(99);
			if (k < 50)
				it.char_code = CH_SPACE + 8'($urandom_range(95));
			else if (k < 70)
				it.char_code = CH_NL;
			else if (k < 78)
				it.char_code = CH_TAB;
			else if (k < 88)
				it.char_code = CH_BS;
			else if (k < 91)
				it.char_code = CH_CR;
			else if (k < 95)
				it.char_code = {3'b000, 5'($urandom)};
			else
				it.char_code = {1'b1, 7'($urandom)};
		end
		return it;
	endfunction

	// Response side: random ready, a steady window and one long hold-off
	initial begin
		int got;
		bit held;
		got  = 0;
		held = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				got++;
			if (!held && got >= HOLD_AT_RSP) begin
				held = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (got >= RCV_STEADY_FROM && got < RCV_STEADY_TO) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Stimulus and verdict
	initial begin
		int sent;
		int n;
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_data      = '0;
		req_ch.valid  = 1'b0;
		req_ch.data   = '0;
		sender_steady = 1'b0;
		sent          = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed opening, backspace color at its reset value
		send_op(MODE_READ, 8'h00, 8'h00, 11'd0);
		send_op(MODE_WRITE, 8'h41, 8'h00, 11'd0);
		send_op(MODE_WRITE, 8'h7F, 8'hFF, 11'd0);
		send_op(MODE_WRITE, CH_SPACE, 8'h5A, 11'd0);
		send_op(MODE_WRITE, 8'h1F, 8'h33, 11'd0);
		send_op(MODE_WRITE, 8'h80, 8'h44, 11'd0);
		send_op(MODE_WRITE, 8'hFF, 8'hFF, 11'd0);
		send_op(MODE_WRITE, CH_TAB, 8'h00, 11'd0);
		// backspace inside a line
		send_op(MODE_WRITE, CH_BS, 8'h00, 11'd0);
		send_op(MODE_WRITE, CH_CR, 8'h00, 11'd0);
		// backspace at home position
		send_op(MODE_WRITE, CH_BS, 8'h00, 11'd0);
		send_op(MODE_WRITE, CH_NL, 8'h00, 11'd0);
		// backspace at line start goes to the last column of the row above
		send_op(MODE_WRITE, CH_BS, 8'h00, 11'd0);
		// character in the last column wraps the cursor
		send_op(MODE_WRITE, 8'h5A, 8'hA5, 11'd0);
		send_op(MODE_READ, 8'h00, 8'h00, 11'(COLS - 1));
		send_op(MODE_READ, 8'h00, 8'h00, 11'd0);
		send_op(MODE_READ, 8'h00, 8'h00, 11'd1);
		send_op(MODE_READ, 8'h00, 8'h00, 11'(NCELLS - 1));
		// reads past the end of the store
		send_op(MODE_READ, 8'h00, 8'h00, 11'(NCELLS));
		send_op(MODE_READ, 8'hFF, 8'hFF, 11'(IDX_LAST));
		send_op(MODE_UNUSED, 8'hFF, 8'hFF, 11'(IDX_LAST));
		send_op(MODE_CLEAR, 8'h41, 8'h41, 11'd5);
		send_op(MODE_READ, 8'h00, 8'h00, 11'd0);

		// random phases, each under its own backspace color
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: write_color(8'hFF);
				1: write_color(8'h00);
				default: write_color(8'($urandom_range(255)));
			endcase
			n = 0;
			if (ph == NUM_PHASES - 1) begin
				// feed to a pending scroll, then read and clear must not scroll
				repeat (ROWS + 1) send_op(MODE_WRITE, CH_NL, 8'h00, 11'd0);
				send_op(MODE_READ, 8'h00, 8'h00, 11'(NCELLS - COLS));
				send_op(MODE_CLEAR, 8'h00, 8'h00, 11'd0);
				send_op(MODE_READ, 8'h00, 8'h00, 11'(NCELLS - 1));
				n = ROWS + 4;
			end
			for (; n < ITEMS_PER_PHASE; n++) begin
				sender_steady = (sent >= SND_STEADY_FROM && sent < SND_STEADY_TO);
				send_txn(random_item());
				sent++;
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("[text_console_char_writer_top] OK");
		else
			$display("[text_console_char_writer_top] ERROR");
		$finish;
	end

	// Run limit
	initial begin
		#200ms;
		$display("[text_console_char_writer_top] ERROR");
		$finish;
	end

endmodule
